FILE: sv/lifeg_pkg.sv
// ----------------------------------------------------------------------------
// lifeg_pkg
// Shared types and constants of the life automaton grid step core: grid size,
// mode codes, input and result words, and the controller command word.
// ----------------------------------------------------------------------------
package lifeg_pkg;

  localparam int GRID_SIZE = 32;
  localparam int ADDR_W    = $clog2(GRID_SIZE);
  localparam int CNT_W     = $clog2(GRID_SIZE + 2);

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_STEP  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  typedef logic [GRID_SIZE-1:0] lifeg_row_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] row;
    logic [4:0] col;
    logic       value;
  } lifeg_in_t;

  typedef struct packed {
    logic [31:0] row_bits;
    logic [15:0] generation;
  } lifeg_out_t;

  typedef struct packed {
    logic             capture;
    logic             win_clear;
    logic             win_shift;
    logic             tail;
    logic             rd_en;
    logic             rd_sweep;
    logic             wr_sweep;
    logic             wr_item;
    logic             out_load;
    logic             gen_inc;
    logic [CNT_W-1:0] cnt;
  } lifeg_cmd_t;

endpackage

FILE: sv/lifeg_ram.sv
// ----------------------------------------------------------------------------
// lifeg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lifeg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/lifeg_datapath.sv
// ----------------------------------------------------------------------------
// lifeg_datapath
// Grid store, valid bits, three-row window with the B3/S23 next-row logic,
// generation counter and the result word register.
// ----------------------------------------------------------------------------
module lifeg_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lifeg_pkg::lifeg_cmd_t cmd,
  input  lifeg_pkg::lifeg_in_t  in_word,
  output lifeg_pkg::lifeg_out_t out_word
);
  import lifeg_pkg::*;

  function automatic lifeg_row_t life_next(lifeg_row_t up, lifeg_row_t mid, lifeg_row_t dn);
    lifeg_row_t res;
    logic [3:0] n;
    res = '0;
    for (int c = 0; c < GRID_SIZE; c++) begin
      n = {3'b0, up[c]} + {3'b0, dn[c]};
      if (c > 0) begin
        n = n + {3'b0, up[c-1]} + {3'b0, mid[c-1]} + {3'b0, dn[c-1]};
      end
      if (c < GRID_SIZE - 1) begin
        n = n + {3'b0, up[c+1]} + {3'b0, mid[c+1]} + {3'b0, dn[c+1]};
      end
      res[c] = (n == 4'd3) || (mid[c] && (n == 4'd2));
    end
    return res;
  endfunction

  lifeg_in_t             item_r;
  logic                  row_ok_r;
  logic                  col_ok_r;
  logic [GRID_SIZE-1:0]  valid_r;
  logic                  rvld_r;
  lifeg_row_t            mid_r;
  lifeg_row_t            dn_r;
  logic [15:0]           gen_r;
  lifeg_out_t            out_r;

  logic [ADDR_W-1:0]     row_addr;
  logic [ADDR_W-1:0]     raddr;
  logic [ADDR_W-1:0]     waddr;
  logic [CNT_W-1:0]      cnt_m2;
  logic                  we;
  logic                  write_ok;
  lifeg_row_t            wdata;
  lifeg_row_t            ram_q;
  lifeg_row_t            rd_row;
  lifeg_row_t            dn_in;
  lifeg_row_t            new_row;
  lifeg_row_t            mod_row;
  lifeg_row_t            res_row;

  assign row_addr = ADDR_W'(item_r.row);
  assign cnt_m2   = cmd.cnt - CNT_W'(2);
  assign raddr    = cmd.rd_sweep ? cmd.cnt[ADDR_W-1:0] : row_addr;
  assign rd_row   = rvld_r ? ram_q : '0;
  assign dn_in    = cmd.tail ? '0 : rd_row;
  assign new_row  = life_next(mid_r, dn_r, dn_in);
  assign write_ok = (item_r.mode == MODE_WRITE) && row_ok_r && col_ok_r;

  always_comb begin
    mod_row = rd_row;
    mod_row[ADDR_W'(item_r.col)] = item_r.value;
  end

  assign we      = cmd.wr_sweep || (cmd.wr_item && write_ok);
  assign waddr   = cmd.wr_sweep ? cnt_m2[ADDR_W-1:0] : row_addr;
  assign wdata   = cmd.wr_sweep ? new_row : mod_row;
  assign res_row = write_ok ? mod_row : rd_row;

  lifeg_ram #(
    .WIDTH(GRID_SIZE),
    .DEPTH(GRID_SIZE)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
      gen_r   <= '0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rvld_r <= valid_r[raddr];
      end
      if (cmd.gen_inc) begin
        gen_r <= gen_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r   <= in_word;
      row_ok_r <= int'(in_word.row) < GRID_SIZE;
      col_ok_r <= int'(in_word.col) < GRID_SIZE;
    end
    if (cmd.win_clear) begin
      mid_r <= '0;
      dn_r  <= '0;
    end else if (cmd.win_shift) begin
      mid_r <= dn_r;
      dn_r  <= dn_in;
    end
    if (cmd.out_load) begin
      out_r.row_bits   <= row_ok_r ? 32'(res_row) : 32'd0;
      out_r.generation <= gen_r;
    end
  end

  assign out_word = out_r;

endmodule

FILE: sv/lifeg_ctrl.sv
// ----------------------------------------------------------------------------
// lifeg_ctrl
// Controller: accepts a word, runs the row sweep of a step or the single row
// access of a read or write, and strobes the result.
// ----------------------------------------------------------------------------
module lifeg_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [1:0]            in_mode,
  output logic                  busy,
  output logic                  out_strobe,
  output lifeg_pkg::lifeg_cmd_t cmd
);
  import lifeg_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_READ,
    S_DONE
  } state_t;

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             strobe_r;
  logic             last;

  assign last = (cnt_r == CNT_W'(GRID_SIZE + 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          state_nxt = (in_mode == MODE_STEP) ? S_SWEEP : S_READ;
        end
      end
      S_SWEEP: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last) begin
          state_nxt = S_READ;
        end
      end
      S_READ:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= (state_r == S_DONE);
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.cnt       = cnt_r;
    cmd.capture   = (state_r == S_IDLE) && start;
    cmd.win_clear = cmd.capture;
    case (state_r)
      S_SWEEP: begin
        cmd.rd_sweep  = 1'b1;
        cmd.rd_en     = cnt_r < CNT_W'(GRID_SIZE);
        cmd.win_shift = cnt_r != '0;
        cmd.wr_sweep  = cnt_r >= CNT_W'(2);
        cmd.tail      = last;
        cmd.gen_inc   = last;
      end
      S_READ:  cmd.rd_en = 1'b1;
      S_DONE: begin
        cmd.out_load = 1'b1;
        cmd.wr_item  = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;

endmodule

FILE: sv/life_automaton_grid_step_core.sv
// ----------------------------------------------------------------------------
// life_automaton_grid_step_core
// 32 x 32 B3/S23 life grid: write one cell, advance one generation, read one
// row. Every accepted word gives one result word.
// ----------------------------------------------------------------------------
// A word is taken on a rising edge with start high and busy low. Busy rises
// on acceptance; the result appears on out_word with out_strobe high for
// exactly one cycle, and the receiver cannot stall it, so capture it then. A
// new word may be offered in the strobe cycle. A write or read reads one row
// of the grid RAM, and a write writes it back with the cell changed. A step
// sweeps the grid RAM's single read port one row per cycle through a
// three-row window, each new row written back once the row below it has
// been read, then the addressed row is read out. Grid contents are dead
// after reset through per-row valid bits; no clearing pass is run.
// ----------------------------------------------------------------------------
module life_automaton_grid_step_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  lifeg_pkg::lifeg_in_t  in_word,
  output logic                  out_strobe,
  output lifeg_pkg::lifeg_out_t out_word
);
  import lifeg_pkg::*;

  lifeg_cmd_t cmd;

  lifeg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_word.mode),
    .busy      (busy),
    .out_strobe(out_strobe),
    .cmd       (cmd)
  );

  lifeg_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_word (in_word),
    .out_word(out_word)
  );

endmodule

FILE: verif/tb_life_automaton_grid_step_core.sv
// ----------------------------------------------------------------------------
// tb_life_automaton_grid_step_core
// Self-checking bench for the 32 x 32 life grid core. A short table of
// directed words covers the edges, the corners, every mode and still lifes,
// oscillators and births against the grid border. Random writes, steps,
// reads and spare-mode words follow, with gliders dropped at random places.
// A shadow grid predicts each result word, or the table fixes it, and it
// is compared field by field with the strobed output.
// ----------------------------------------------------------------------------
module tb_life_automaton_grid_step_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lifeg_pkg::*;

  localparam logic [1:0] MODE_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         RANDOM_WORDS = 650;
  localparam int         DRAIN_CYCLES = 60;

  typedef struct {
    lifeg_in_t  word;
    bit         fixed;
    lifeg_out_t res;
  } probe_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  lifeg_in_t  in_word;
  logic       out_strobe;
  lifeg_out_t out_word;

  lifeg_row_t shadow_grid [GRID_SIZE];
  logic [15:0] shadow_gen;
  lifeg_out_t row_reports_due [$];
  probe_t     probes [$];
  int         errors = 0;
  int         cycles = 0;
  int         words_sent = 0;
  bit         quiet_run = 1'b0;

  life_automaton_grid_step_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int live_at(lifeg_row_t bits, int c);
    if (c < 0 || c >= GRID_SIZE) return 0;
    return int'(bits[c]);
  endfunction

  function automatic void advance_grid();
    lifeg_row_t nxt [GRID_SIZE];
    lifeg_row_t up;
    lifeg_row_t mid;
    lifeg_row_t dn;
    int         cnt;
    for (int r = 0; r < GRID_SIZE; r++) begin
      up     = (r > 0) ? shadow_grid[r-1] : '0;
      mid    = shadow_grid[r];
      dn     = (r + 1 < GRID_SIZE) ? shadow_grid[r+1] : '0;
      nxt[r] = '0;
      for (int c = 0; c < GRID_SIZE; c++) begin
        cnt = live_at(up, c-1) + live_at(up, c) + live_at(up, c+1)
            + live_at(mid, c-1) + live_at(mid, c+1)
            + live_at(dn, c-1) + live_at(dn, c) + live_at(dn, c+1);
        nxt[r][c] = (cnt == 3) || (mid[c] && cnt == 2);
      end
    end
    shadow_grid = nxt;
    shadow_gen  = shadow_gen + 16'd1;
  endfunction

  function automatic lifeg_out_t apply_word(lifeg_in_t w);
    lifeg_out_t res;
    case (w.mode)
      MODE_WRITE: begin
        if (w.row < GRID_SIZE && w.col < GRID_SIZE) shadow_grid[w.row][w.col] = w.value;
      end
      MODE_STEP: begin
        advance_grid();
      end
      default: begin
      end
    endcase
    res.row_bits   = (w.row < GRID_SIZE) ? shadow_grid[w.row] : '0;
    res.generation = shadow_gen;
    return res;
  endfunction

  function automatic lifeg_in_t make_word(logic [1:0] m, int r, int c, bit v);
    lifeg_in_t w;
    w.mode  = m;
    w.row   = r[4:0];
    w.col   = c[4:0];
    w.value = v;
    return w;
  endfunction

  function automatic void add_probe(logic [1:0] m, int r, int c, bit v, bit fixed,
                                    logic [31:0] bits, logic [15:0] gen);
    probe_t p;
    p.word           = make_word(m, r, c, v);
    p.fixed          = fixed;
    p.res.row_bits   = bits;
    p.res.generation = gen;
    probes.push_back(p);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic issue(lifeg_in_t w, bit fixed, lifeg_out_t res);
    int         pick;
    int         gap;
    lifeg_out_t due;
    pick = $urandom_range(0, 99);
    if (quiet_run || pick < 50) gap = 0;
    else if (pick < 90)         gap = $urandom_range(1, 3);
    else                        gap = $urandom_range(8, 40);
    repeat (gap) begin
      @(negedge clk);
      start   <= 1'b0;
      in_word <= lifeg_in_t'($urandom_range(0, 8191));
    end
    @(negedge clk);
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    due = apply_word(w);
    if (fixed) due = res;
    row_reports_due.push_back(due);
    words_sent++;
  endtask

  always @(posedge clk) begin : watch_results
    lifeg_out_t head;
    if (rst_n && out_strobe) begin
      if (row_reports_due.size() == 0) begin
        report_mismatch("result word with none due", out_word.row_bits, '0);
      end else begin
        head = row_reports_due.pop_front();
        if (out_word.row_bits !== head.row_bits)
          report_mismatch("row_bits", out_word.row_bits, head.row_bits);
        if (out_word.generation !== head.generation)
          report_mismatch("generation", {16'd0, out_word.generation},
                          {16'd0, head.generation});
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    lifeg_out_t none;
    int         pick;
    int         r0;
    int         c0;
    none    = '0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_word = '0;
    foreach (shadow_grid[i]) shadow_grid[i] = '0;
    shadow_gen = 16'd0;

    add_probe(MODE_READ,  0,  0,  0, 1, 32'h0000_0000, 16'd0);
    add_probe(MODE_SPARE, 31, 31, 1, 1, 32'h0000_0000, 16'd0);
    add_probe(MODE_WRITE, 0,  0,  1, 1, 32'h0000_0001, 16'd0);
    add_probe(MODE_WRITE, 0,  31, 1, 1, 32'h8000_0001, 16'd0);
    add_probe(MODE_WRITE, 31, 31, 1, 1, 32'h8000_0000, 16'd0);
    add_probe(MODE_WRITE, 31, 0,  1, 1, 32'h8000_0001, 16'd0);
    add_probe(MODE_STEP,  0,  0,  0, 1, 32'h0000_0000, 16'd1);
    add_probe(MODE_READ,  31, 0,  0, 1, 32'h0000_0000, 16'd1);
    add_probe(MODE_WRITE, 0,  0,  1, 0, '0, '0);
    add_probe(MODE_WRITE, 0,  1,  1, 0, '0, '0);
    add_probe(MODE_WRITE, 1,  0,  1, 0, '0, '0);
    add_probe(MODE_WRITE, 1,  1,  1, 0, '0, '0);
    add_probe(MODE_WRITE, 15, 14, 1, 0, '0, '0);
    add_probe(MODE_WRITE, 15, 15, 1, 0, '0, '0);
    add_probe(MODE_WRITE, 15, 16, 1, 0, '0, '0);
    add_probe(MODE_WRITE, 9,  31, 1, 0, '0, '0);
    add_probe(MODE_WRITE, 10, 30, 1, 0, '0, '0);
    add_probe(MODE_WRITE, 10, 31, 1, 0, '0, '0);
    add_probe(MODE_WRITE, 31, 4,  1, 0, '0, '0);
    add_probe(MODE_WRITE, 31, 6,  1, 0, '0, '0);
    add_probe(MODE_STEP,  15, 0,  0, 0, '0, '0);
    add_probe(MODE_READ,  14, 0,  0, 0, '0, '0);
    add_probe(MODE_STEP,  30, 0,  0, 0, '0, '0);
    add_probe(MODE_WRITE, 0,  0,  0, 0, '0, '0);
    add_probe(MODE_STEP,  9,  0,  0, 0, '0, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (probes[i]) issue(probes[i].word, probes[i].fixed, probes[i].res);

    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 49) == 0) quiet_run = !quiet_run;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        r0 = $urandom_range(0, 31);
        c0 = $urandom_range(0, 31);
        issue(make_word(MODE_WRITE, r0,     c0 + 1, 1), 0, none);
        issue(make_word(MODE_WRITE, r0 + 1, c0 + 2, 1), 0, none);
        issue(make_word(MODE_WRITE, r0 + 2, c0,     1), 0, none);
        issue(make_word(MODE_WRITE, r0 + 2, c0 + 1, 1), 0, none);
        issue(make_word(MODE_WRITE, r0 + 2, c0 + 2, 1), 0, none);
        repeat ($urandom_range(1, 6))
          issue(make_word(MODE_STEP, $urandom_range(0, 31), $urandom_range(0, 31),
                          1'($urandom_range(0, 1))), 0, none);
      end else if (pick < 55) begin
        issue(make_word(MODE_WRITE, $urandom_range(0, 31), $urandom_range(0, 31),
                        1'($urandom_range(0, 1))), 0, none);
      end else if (pick < 70) begin
        issue(make_word(MODE_STEP, $urandom_range(0, 31), $urandom_range(0, 31),
                        1'($urandom_range(0, 1))), 0, none);
      end else if (pick < 92) begin
        issue(make_word(MODE_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                        1'($urandom_range(0, 1))), 0, none);
      end else begin
        issue(make_word(MODE_SPARE, $urandom_range(0, 31), $urandom_range(0, 31),
                        1'($urandom_range(0, 1))), 0, none);
      end
    end
    @(negedge clk);
    start <= 1'b0;

    while (row_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/lifeg_pkg.sv
sv/lifeg_ram.sv
sv/lifeg_datapath.sv
sv/lifeg_ctrl.sv
sv/life_automaton_grid_step_core.sv
verif/tb_life_automaton_grid_step_core.sv
